// ----- design/oqs_pkg.sv -----
// Shared types, constants and a helper function for the ordered queue with shuffle.
`timescale 1ns / 1ps
package oqs_pkg;

    // Default sizes of the list store.
    localparam int DEF_LIST_DEPTH = 32;
    localparam int DEF_ID_BITS    = 16;

    // Seed reset value and the Galois feedback taps.
    localparam logic [15:0] SEED_RESET = 16'd44257;
    localparam logic [15:0] LFSR_TAPS  = 16'hB400;

    // Action codes.
    typedef enum logic [2:0] {
        ACT_APPEND  = 3'd0,
        ACT_DELETE  = 3'd1,
        ACT_PLAY    = 3'd2,
        ACT_SHUFFLE = 3'd3,
        ACT_LIST    = 3'd4
    } action_t;

    // Status codes.
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_INDEX = 2'd2,
        ST_FULL  = 2'd3
    } status_t;

    // One step of the 16-bit Galois shift register.
    function automatic logic [15:0] lfsr_next(input logic [15:0] s);
        logic [15:0] t;
        t = {1'b0, s[15:1]};
        if (s[0])
        begin
            t = t ^ LFSR_TAPS;
        end
        return t;
    endfunction

endpackage

// ----- design/ordered_queue_with_shuffle_core.sv -----
// Top level: ordered entry list with play-next, delete, list and LFSR shuffle.
`timescale 1ns / 1ps
// An action is accepted when start is high and busy is low; busy stays high until the
// final result of that action has been strobed on done, and results cannot be stalled.
// Append and all error or empty cases finish without leaving idle (result next cycle).
// Delete and play-next read the removed entry and then shift the tail up one place,
// reading and then writing each moved entry. List gives one result per entry, each
// after a wait state. Shuffle runs a bit-serial modulo unit over the 16 LFSR bits
// for each swap, then reads entries i and j and writes them back swapped. The list
// store is a single-port-write, single-port-read memory with a registered read, and
// that port sets the per-entry cost of the shift and list loops.
module ordered_queue_with_shuffle_core
    import oqs_pkg::*;
#(
    parameter int LIST_DEPTH = DEF_LIST_DEPTH,
    parameter int ID_BITS    = DEF_ID_BITS
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  action,
    input  logic [15:0] entry_id,
    input  logic [4:0]  position,
    input  logic        seed_we,
    input  logic [15:0] seed_wdata,
    output logic        done,
    output logic [1:0]  status,
    output logic [15:0] item_id,
    output logic [4:0]  item_index,
    output logic        playing_valid,
    output logic [15:0] playing_id,
    output logic [5:0]  list_count,
    output logic        last
);

    localparam int IDX_W = $clog2(LIST_DEPTH);
    localparam int CNT_W = $clog2(LIST_DEPTH + 1);
    localparam int REM_W = CNT_W + 1;

    typedef enum logic [11:0] {
        S_IDLE    = 12'b000000000001,
        S_GONE_WT = 12'b000000000010,
        S_GONE    = 12'b000000000100,
        S_SHIFT   = 12'b000000001000,
        S_SH_WT   = 12'b000000010000,
        S_SH_WR   = 12'b000000100000,
        S_SW_CHK  = 12'b000001000000,
        S_MOD     = 12'b000010000000,
        S_SW_WI   = 12'b000100000000,
        S_SW_WJ   = 12'b001000000000,
        S_SW_WRJ  = 12'b010000000000,
        S_LS_WT   = 12'b100000000000
    } state_t;

    // Control and bookkeeping registers.
    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [ID_BITS-1:0] cur_id_reg, cur_id_next;
    logic               cur_valid_reg, cur_valid_next;
    logic [15:0]        seed_reg;
    logic [15:0]        lfsr_reg, lfsr_next_v;
    logic               act_play_reg, act_play_next;
    logic [4:0]         pos_reg, pos_next;
    logic [IDX_W-1:0]   k_reg, k_next;
    logic [IDX_W-1:0]   addr_reg, addr_next;
    logic [ID_BITS-1:0] hold_reg, hold_next;

    // Modulo unit for the shuffle.
    logic [15:0]        dvd_reg, dvd_next;
    logic [REM_W-1:0]   rem_reg, rem_next;
    logic [3:0]         bit_reg, bit_next;
    logic [REM_W-1:0]   rem_shift;
    logic [REM_W-1:0]   divisor;

    // Result registers.
    logic               done_reg, done_next;
    status_t            status_reg, status_next;
    logic [15:0]        item_reg, item_next;
    logic [4:0]         index_reg, index_next;
    logic               last_reg, last_next;

    // List memory.
    logic [ID_BITS-1:0] order_mem [LIST_DEPTH];
    logic [ID_BITS-1:0] rd_data_reg;
    logic               wr_en;
    logic [IDX_W-1:0]   wr_addr;
    logic [ID_BITS-1:0] wr_data;

    logic [6:0]         cnt7;
    logic [6:0]         pos7;
    logic [6:0]         k7;

    assign cnt7      = 7'(count_reg);
    assign pos7      = 7'(position);
    assign k7        = 7'(k_reg);
    assign divisor   = REM_W'(k_reg) + REM_W'(1);
    assign rem_shift = {rem_reg[REM_W-2:0], dvd_reg[15]};

    // Memory write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            order_mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= order_mem[addr_reg];
    end

    // Sequencer.
    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        cur_id_next    = cur_id_reg;
        cur_valid_next = cur_valid_reg;
        lfsr_next_v    = lfsr_reg;
        act_play_next  = act_play_reg;
        pos_next       = pos_reg;
        k_next         = k_reg;
        addr_next      = addr_reg;
        hold_next      = hold_reg;
        dvd_next       = dvd_reg;
        rem_next       = rem_reg;
        bit_next       = bit_reg;
        done_next      = 1'b0;
        status_next    = status_reg;
        item_next      = item_reg;
        index_next     = index_reg;
        last_next      = last_reg;
        wr_en          = 1'b0;
        wr_addr        = addr_reg;
        wr_data        = rd_data_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    done_next     = 1'b1;
                    status_next   = ST_OK;
                    item_next     = 16'd0;
                    index_next    = 5'd0;
                    last_next     = 1'b1;
                    pos_next      = position;
                    act_play_next = (action == ACT_PLAY);
                    case (action)
                        ACT_APPEND:
                        begin
                            item_next = 16'(ID_BITS'(entry_id));
                            if (cnt7 == 7'(LIST_DEPTH))
                            begin
                                status_next = ST_FULL;
                            end
                            else
                            begin
                                wr_en      = 1'b1;
                                wr_addr    = IDX_W'(count_reg);
                                wr_data    = ID_BITS'(entry_id);
                                index_next = 5'(count_reg);
                                count_next = count_reg + CNT_W'(1);
                            end
                        end
                        ACT_DELETE, ACT_PLAY:
                        begin
                            if (action == ACT_DELETE)
                            begin
                                index_next = position;
                            end
                            if (count_reg == '0)
                            begin
                                status_next = ST_EMPTY;
                            end
                            else if (action == ACT_DELETE && pos7 >= cnt7)
                            begin
                                status_next = ST_INDEX;
                            end
                            else
                            begin
                                done_next = 1'b0;
                                k_next    = (action == ACT_DELETE) ?
                                            IDX_W'(position) : '0;
                                addr_next = (action == ACT_DELETE) ?
                                            IDX_W'(position) : '0;
                                state_next = S_GONE_WT;
                            end
                        end
                        ACT_SHUFFLE:
                        begin
                            if (count_reg == '0)
                            begin
                                status_next = ST_EMPTY;
                            end
                            else
                            begin
                                done_next   = 1'b0;
                                lfsr_next_v = seed_reg;
                                k_next      = IDX_W'(count_reg - CNT_W'(1));
                                state_next  = S_SW_CHK;
                            end
                        end
                        ACT_LIST:
                        begin
                            if (count_reg == '0)
                            begin
                                status_next = ST_EMPTY;
                            end
                            else
                            begin
                                done_next  = 1'b0;
                                k_next     = '0;
                                addr_next  = '0;
                                state_next = S_LS_WT;
                            end
                        end
                        default:
                        begin
                            status_next = ST_OK;
                        end
                    endcase
                end
            end

            // Wait for the entry being removed.
            S_GONE_WT:
            begin
                state_next = S_GONE;
            end

            S_GONE:
            begin
                hold_next  = rd_data_reg;
                state_next = S_SHIFT;
            end

            // Close the gap one entry at a time, then report.
            S_SHIFT:
            begin
                if (k7 + 7'd1 < cnt7)
                begin
                    addr_next  = k_reg + IDX_W'(1);
                    state_next = S_SH_WT;
                end
                else
                begin
                    count_next  = count_reg - CNT_W'(1);
                    done_next   = 1'b1;
                    status_next = ST_OK;
                    item_next   = 16'(hold_reg);
                    index_next  = act_play_reg ? 5'd0 : pos_reg;
                    last_next   = 1'b1;
                    if (act_play_reg)
                    begin
                        cur_id_next    = hold_reg;
                        cur_valid_next = 1'b1;
                    end
                    state_next = S_IDLE;
                end
            end

            S_SH_WT:
            begin
                state_next = S_SH_WR;
            end

            S_SH_WR:
            begin
                wr_en      = 1'b1;
                wr_addr    = k_reg;
                wr_data    = rd_data_reg;
                k_next     = k_reg + IDX_W'(1);
                state_next = S_SHIFT;
            end

            // Shuffle loop head: finish when i is zero, else step the LFSR and start the modulo.
            S_SW_CHK:
            begin
                if (k_reg == '0)
                begin
                    done_next   = 1'b1;
                    status_next = ST_OK;
                    item_next   = 16'd0;
                    index_next  = 5'd0;
                    last_next   = 1'b1;
                    state_next  = S_IDLE;
                end
                else
                begin
                    lfsr_next_v = lfsr_next(lfsr_reg);
                    dvd_next    = lfsr_next(lfsr_reg);
                    rem_next    = '0;
                    bit_next    = '0;
                    state_next  = S_MOD;
                end
            end

            // One restoring step per cycle of LFSR mod (i+1).
            S_MOD:
            begin
                dvd_next = {dvd_reg[14:0], 1'b0};
                rem_next = (rem_shift >= divisor) ? rem_shift - divisor : rem_shift;
                bit_next = bit_reg + 4'd1;
                if (bit_reg == 4'd15)
                begin
                    addr_next  = k_reg;
                    state_next = S_SW_WI;
                end
            end

            // Read entry i, then entry j.
            S_SW_WI:
            begin
                addr_next  = IDX_W'(rem_reg);
                state_next = S_SW_WJ;
            end

            S_SW_WJ:
            begin
                hold_next  = rd_data_reg;
                state_next = S_SW_WRJ;
            end

            // Entry j's data arrives now: store it at i, then old i goes to j.
            S_SW_WRJ:
            begin
                if (bit_reg == 4'd0)
                begin
                    wr_en    = 1'b1;
                    wr_addr  = k_reg;
                    wr_data  = rd_data_reg;
                    bit_next = 4'd1;
                end
                else
                begin
                    wr_en      = 1'b1;
                    wr_addr    = addr_reg;
                    wr_data    = hold_reg;
                    bit_next   = 4'd0;
                    k_next     = k_reg - IDX_W'(1);
                    state_next = S_SW_CHK;
                end
            end

            // Listing: one result per entry.
            S_LS_WT:
            begin
                if (bit_reg == 4'd0)
                begin
                    bit_next = 4'd1;
                end
                else
                begin
                    bit_next    = 4'd0;
                    done_next   = 1'b1;
                    status_next = ST_OK;
                    item_next   = 16'(rd_data_reg);
                    index_next  = 5'(k_reg);
                    last_next   = (k7 + 7'd1 == cnt7);
                    if (k7 + 7'd1 == cnt7)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        k_next    = k_reg + IDX_W'(1);
                        addr_next = k_reg + IDX_W'(1);
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            cur_id_reg    <= '0;
            cur_valid_reg <= 1'b0;
            seed_reg      <= SEED_RESET;
            lfsr_reg      <= SEED_RESET;
            done_reg      <= 1'b0;
            bit_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            cur_id_reg    <= cur_id_next;
            cur_valid_reg <= cur_valid_next;
            lfsr_reg      <= lfsr_next_v;
            done_reg      <= done_next;
            bit_reg       <= bit_next;
            if (seed_we)
            begin
                seed_reg <= seed_wdata;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        act_play_reg <= act_play_next;
        pos_reg      <= pos_next;
        k_reg        <= k_next;
        addr_reg     <= addr_next;
        hold_reg     <= hold_next;
        dvd_reg      <= dvd_next;
        rem_reg      <= rem_next;
        status_reg   <= status_next;
        item_reg     <= item_next;
        index_reg    <= index_next;
        last_reg     <= last_next;
    end

    assign busy          = (state_reg != S_IDLE);
    assign done          = done_reg;
    assign status        = status_reg;
    assign item_id       = item_reg;
    assign item_index    = index_reg;
    assign last          = last_reg;
    assign playing_valid = cur_valid_reg;
    assign playing_id    = 16'(cur_id_reg);
    assign list_count    = 6'(count_reg);

endmodule

// ----- design/oqs_checker.sv -----
// Port-level checker for the ordered queue with shuffle, and its bind.
`timescale 1ns / 1ps
module oqs_checker
    import oqs_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        start,
    input logic        busy,
    input logic [2:0]  action,
    input logic [15:0] entry_id,
    input logic [4:0]  position,
    input logic        seed_we,
    input logic [15:0] seed_wdata,
    input logic        done,
    input logic [1:0]  status,
    input logic [15:0] item_id,
    input logic [4:0]  item_index,
    input logic        playing_valid,
    input logic [15:0] playing_id,
    input logic [5:0]  list_count,
    input logic        last
);

    // An accepted transaction either reports next cycle or keeps the block busy.
    a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (busy || done))
        else $error("accepted transaction made no progress");

    // The final result of a transaction leaves the block free.
    a_last_frees: assert property (@(posedge clk) disable iff (!rst_n)
        (done && last) |-> !busy)
        else $error("busy after final result");

    // More results to come keep the block busy.
    a_more_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !last) |-> busy)
        else $error("not busy while results remain");

    // A result reporting an empty list shows an empty list.
    a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status == ST_EMPTY) |-> (list_count == 6'd0))
        else $error("empty status with entries present");

    // The current entry only changes together with a reported transaction.
    a_playing_stable: assert property (@(posedge clk) disable iff (!rst_n)
        !done |-> ($stable(playing_id) && $stable(playing_valid)))
        else $error("current entry changed without a result");

endmodule

bind ordered_queue_with_shuffle_core oqs_checker u_oqs_checker (.*);
